// ----- rtl/blru_pkg.sv -----
// blru_pkg: shared widths, register indexes, status codes and the
// command/status structs between the lookup controller and datapath.
// No dependencies.
`default_nettype none

package blru_pkg;

   localparam int MAX_SLOTS_DEF = 64;
   localparam int ASSOC_LIMIT   = 16;
   localparam int SET_WAYS      = 4;

   localparam int TUPLE_W    = 32;
   localparam int BSIZE_W    = 17;
   localparam int SCNT_W     = 7;
   localparam int STAMP_W    = 64;
   localparam int STATUS_W   = 2;
   localparam int SLOT_IDX_W = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int DIV_STEPS  = 32;

   localparam logic [BSIZE_W-1:0] BLOCK_MAX    = 17'd65536;
   localparam logic [TUPLE_W-1:0] UNLOADED_TAG = '1;

   localparam logic [BSIZE_W-1:0] BSIZE_RESET  = BLOCK_MAX;
   localparam logic [TUPLE_W-1:0] TOTAL_RESET  = 32'd1;
   localparam logic [SCNT_W-1:0]  SCNT_RESET   = 7'd16;

   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_TUPLES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_COUNT   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_HIT  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OOR  = 2'd2;

   typedef struct packed {
      logic accept;
      logic div_step;
      logic addr_calc;
      logic len_calc;
      logic issue;
      logic compare;
      logic commit;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic oor;
      logic div_last;
      logic search_done;
   } stat_type;

endpackage

`default_nettype wire

// ----- rtl/blru_csr.sv -----
// blru_csr: configuration registers and their clamped effective values.
// Depends on blru_pkg.
`default_nettype none

module blru_csr #(
   parameter int MAX_SLOTS = blru_pkg::MAX_SLOTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [blru_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [blru_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   output logic [blru_pkg::BSIZE_W-1:0]        block_size_eff,
   output logic [blru_pkg::TUPLE_W-1:0]        total_tuples,
   output logic [$clog2(MAX_SLOTS+1)-1:0]      slot_count_eff
);
   import blru_pkg::*;

   localparam int CNT_W = $clog2(MAX_SLOTS+1);

   logic [BSIZE_W-1:0] block_size_ff, block_size_in;
   logic [TUPLE_W-1:0] total_tuples_ff, total_tuples_in;
   logic [SCNT_W-1:0]  slot_count_ff, slot_count_in;

   always_comb begin
      block_size_in   = block_size_ff;
      total_tuples_in = total_tuples_ff;
      slot_count_in   = slot_count_ff;
      if (csr_wr_en) begin
         if (csr_index == CSR_BLOCK_SIZE) begin
            block_size_in = csr_wr_data[BSIZE_W-1:0];
         end
         if (csr_index == CSR_TOTAL_TUPLES) begin
            total_tuples_in = csr_wr_data[TUPLE_W-1:0];
         end
         if (csr_index == CSR_SLOT_COUNT) begin
            slot_count_in = csr_wr_data[SCNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff   <= BSIZE_RESET;
         total_tuples_ff <= TOTAL_RESET;
         slot_count_ff   <= SCNT_RESET;
      end else begin
         block_size_ff   <= block_size_in;
         total_tuples_ff <= total_tuples_in;
         slot_count_ff   <= slot_count_in;
      end
   end

   // zero acts as one, oversize clamps to the limit
   always_comb begin
      if (block_size_ff == '0) begin
         block_size_eff = BSIZE_W'(1);
      end else if (block_size_ff > BLOCK_MAX) begin
         block_size_eff = BLOCK_MAX;
      end else begin
         block_size_eff = block_size_ff;
      end
   end

   always_comb begin
      if (slot_count_ff == '0) begin
         slot_count_eff = CNT_W'(1);
      end else if (32'(slot_count_ff) > 32'(MAX_SLOTS)) begin
         slot_count_eff = CNT_W'(MAX_SLOTS);
      end else begin
         slot_count_eff = CNT_W'(slot_count_ff);
      end
   end

   assign total_tuples = total_tuples_ff;

endmodule

`default_nettype wire

// ----- rtl/blru_ctrl.sv -----
// blru_ctrl: sequencer for one lookup transaction (divide, address, search,
// commit, respond). Owns the handshake flags. Depends on blru_pkg.
`default_nettype none

module blru_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  blru_pkg::stat_type stat,
   output blru_pkg::cmd_type  cmd
);
   import blru_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHECK  = 3'd1;
   localparam logic [2:0] S_DIV    = 3'd2;
   localparam logic [2:0] S_ADDR   = 3'd3;
   localparam logic [2:0] S_LEN    = 3'd4;
   localparam logic [2:0] S_SEARCH = 3'd5;
   localparam logic [2:0] S_COMMIT = 3'd6;
   localparam logic [2:0] S_OUT    = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = stat.oor ? S_OUT : S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_ADDR;
            end
         end
         S_ADDR: begin
            cmd.addr_calc = 1'b1;
            state_in      = S_LEN;
         end
         S_LEN: begin
            cmd.len_calc = 1'b1;
            cmd.issue    = 1'b1;
            state_in     = S_SEARCH;
         end
         S_SEARCH: begin
            cmd.issue   = 1'b1;
            cmd.compare = 1'b1;
            if (stat.search_done) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: begin
            // hold until the output register is free
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- rtl/blru_dpath.sv -----
// blru_dpath: serial divider with running set modulo, tag and stamp memories,
// way search and the result register. Depends on blru_pkg.
`default_nettype none

module blru_dpath #(
   parameter int MAX_SLOTS = blru_pkg::MAX_SLOTS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  blru_pkg::cmd_type                  cmd,
   output blru_pkg::stat_type                 stat,
   input  logic [blru_pkg::TUPLE_W-1:0]       req_tuple_index,
   input  logic [blru_pkg::BSIZE_W-1:0]       block_size_eff,
   input  logic [blru_pkg::TUPLE_W-1:0]       total_tuples,
   input  logic [$clog2(MAX_SLOTS+1)-1:0]     slot_count_eff,
   output logic [blru_pkg::STATUS_W-1:0]      rsp_status,
   output logic [blru_pkg::SLOT_IDX_W-1:0]    rsp_slot_index,
   output logic [blru_pkg::TUPLE_W-1:0]       rsp_block_number,
   output logic [blru_pkg::TUPLE_W-1:0]       rsp_block_start,
   output logic [blru_pkg::BSIZE_W-1:0]       rsp_block_length
);
   import blru_pkg::*;

   localparam int CNT_W  = $clog2(MAX_SLOTS+1);
   localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int DIVC_W = $clog2(DIV_STEPS);

   // request and divider state
   logic [TUPLE_W-1:0] tidx_ff, tidx_in;
   logic               oor_ff, oor_in;
   logic [TUPLE_W-1:0] dvd_ff, dvd_in;
   logic [TUPLE_W-1:0] quo_ff, quo_in;
   logic [BSIZE_W-1:0] rem_ff, rem_in;
   logic [SLOT_W-1:0]  set_ff, set_in;
   logic [DIVC_W-1:0]  cnt_ff, cnt_in;

   // block geometry
   logic [TUPLE_W-1:0] start_ff, start_in;
   logic [BSIZE_W-1:0] len_ff, len_in;

   // search
   logic [CNT_W-1:0]   rd_way_ff, rd_way_in;
   logic [CNT_W-1:0]   lim_ff, lim_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [CNT_W-1:0]   cmp_way_ff, cmp_way_in;
   logic               have_ff, have_in;
   logic               hit_ff, hit_in;
   logic [SLOT_W-1:0]  pick_ff, pick_in;
   logic [STAMP_W-1:0] best_ff, best_in;
   logic [STAMP_W-1:0] use_ctr_ff, use_ctr_in;
   logic [MAX_SLOTS-1:0] valid_ff, valid_in;

   // memories and their registered read data
   logic [TUPLE_W-1:0] tag_mem [MAX_SLOTS];
   logic [STAMP_W-1:0] stamp_mem [MAX_SLOTS];
   logic [TUPLE_W-1:0] rd_tag_ff;
   logic [STAMP_W-1:0] rd_stamp_ff;
   logic               rd_valid_ff;

   // result register
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [SLOT_IDX_W-1:0] slot_ff, slot_in;
   logic [TUPLE_W-1:0]    bnum_ff, bnum_in;
   logic [TUPLE_W-1:0]    bstart_ff, bstart_in;
   logic [BSIZE_W-1:0]    blen_ff, blen_in;

   // combinational helpers
   logic [BSIZE_W:0]   rem_sh, rem_sub;
   logic               q_bit;
   logic [SLOT_W:0]    mod_sh, sets_w;
   logic [31:0]        n32, sets32, ways32, base32, lim32;
   logic               n_big;
   logic [TUPLE_W-1:0] diff;
   logic               issue_now;
   logic [TUPLE_W-1:0] eff_tag;
   logic [STAMP_W-1:0] eff_stamp;
   logic               way_hit, way_empty, way_last;
   logic [SLOT_W-1:0]  rd_addr, wr_addr;

   // geometry from slot count
   assign n32    = 32'(slot_count_eff);
   assign n_big  = n32 > 32'(ASSOC_LIMIT);
   assign sets32 = n_big ? ((n32 + 32'(SET_WAYS - 1)) >> 2) : 32'd1;
   assign ways32 = n_big ? 32'(SET_WAYS) : n32;
   assign sets_w = (SLOT_W+1)'(sets32);
   assign base32 = 32'(set_ff) << 2;

   always_comb begin
      lim32 = base32 + ways32;
      if (lim32 > n32) begin
         lim32 = n32;
      end
   end

   // one restoring step; the quotient bit also feeds the set residue
   assign rem_sh  = {rem_ff, dvd_ff[TUPLE_W-1]};
   assign rem_sub = rem_sh - {1'b0, block_size_eff};
   assign q_bit   = rem_sh >= {1'b0, block_size_eff};
   assign mod_sh  = {set_ff, q_bit};

   assign diff = total_tuples - start_ff;

   // search compare stage
   assign eff_tag   = rd_valid_ff ? rd_tag_ff : UNLOADED_TAG;
   assign eff_stamp = rd_valid_ff ? rd_stamp_ff : '0;
   assign way_hit   = eff_tag == quo_ff;
   assign way_empty = eff_tag == UNLOADED_TAG;
   assign way_last  = cmp_way_ff == (lim_ff - CNT_W'(1));
   assign issue_now = cmd.issue && (rd_way_ff != lim_ff);
   assign rd_addr   = rd_way_ff[SLOT_W-1:0];
   assign wr_addr   = pick_ff;

   assign stat.oor         = oor_ff;
   assign stat.div_last    = cnt_ff == DIVC_W'(DIV_STEPS - 1);
   assign stat.search_done = cmp_vld_ff && (way_hit || way_empty || way_last);

   always_comb begin
      tidx_in   = tidx_ff;
      oor_in    = oor_ff;
      dvd_in    = dvd_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      set_in    = set_ff;
      cnt_in    = cnt_ff;
      start_in  = start_ff;
      len_in    = len_ff;
      rd_way_in = rd_way_ff;
      lim_in    = lim_ff;
      have_in   = have_ff;
      hit_in    = hit_ff;
      pick_in   = pick_ff;
      best_in   = best_ff;
      use_ctr_in = use_ctr_ff;
      valid_in  = valid_ff;
      cmp_vld_in = issue_now;
      cmp_way_in = rd_way_ff;

      if (cmd.accept) begin
         tidx_in = req_tuple_index;
         oor_in  = req_tuple_index >= total_tuples;
         dvd_in  = req_tuple_index;
         quo_in  = '0;
         rem_in  = '0;
         set_in  = '0;
         cnt_in  = '0;
      end

      if (cmd.div_step) begin
         dvd_in = {dvd_ff[TUPLE_W-2:0], 1'b0};
         quo_in = {quo_ff[TUPLE_W-2:0], q_bit};
         rem_in = q_bit ? rem_sub[BSIZE_W-1:0] : rem_sh[BSIZE_W-1:0];
         set_in = (mod_sh >= sets_w) ? SLOT_W'(mod_sh - sets_w) : SLOT_W'(mod_sh);
         cnt_in = cnt_ff + DIVC_W'(1);
      end

      if (cmd.addr_calc) begin
         start_in  = tidx_ff - TUPLE_W'(rem_ff);
         rd_way_in = CNT_W'(base32);
         lim_in    = CNT_W'(lim32);
         have_in   = 1'b0;
         hit_in    = 1'b0;
      end

      if (cmd.len_calc) begin
         len_in = (diff > TUPLE_W'(block_size_eff)) ? block_size_eff : diff[BSIZE_W-1:0];
      end

      if (issue_now) begin
         rd_way_in = rd_way_ff + CNT_W'(1);
      end

      if (cmd.compare && cmp_vld_ff) begin
         if (way_hit) begin
            pick_in = cmp_way_ff[SLOT_W-1:0];
            hit_in  = 1'b1;
            have_in = 1'b1;
         end else if (way_empty) begin
            pick_in = cmp_way_ff[SLOT_W-1:0];
            have_in = 1'b1;
         end else if (!have_ff || (eff_stamp < best_ff)) begin
            pick_in = cmp_way_ff[SLOT_W-1:0];
            best_in = eff_stamp;
            have_in = 1'b1;
         end
      end

      if (cmd.commit) begin
         valid_in[wr_addr] = 1'b1;
         use_ctr_in        = use_ctr_ff + STAMP_W'(1);
      end
   end

   always_comb begin
      status_in = status_ff;
      slot_in   = slot_ff;
      bnum_in   = bnum_ff;
      bstart_in = bstart_ff;
      blen_in   = blen_ff;
      if (cmd.load_rsp) begin
         if (oor_ff) begin
            status_in = ST_OOR;
            slot_in   = '0;
            bnum_in   = '0;
            bstart_in = '0;
            blen_in   = '0;
         end else begin
            status_in = hit_ff ? ST_HIT : ST_MISS;
            slot_in   = SLOT_IDX_W'(pick_ff);
            bnum_in   = quo_ff;
            bstart_in = start_ff;
            blen_in   = len_ff;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         cmp_vld_ff <= 1'b0;
         have_ff    <= 1'b0;
         hit_ff     <= 1'b0;
         oor_ff     <= 1'b0;
         use_ctr_ff <= STAMP_W'(1);
         valid_ff   <= '0;
      end else begin
         cnt_ff     <= cnt_in;
         cmp_vld_ff <= cmp_vld_in;
         have_ff    <= have_in;
         hit_ff     <= hit_in;
         oor_ff     <= oor_in;
         use_ctr_ff <= use_ctr_in;
         valid_ff   <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      tidx_ff    <= tidx_in;
      dvd_ff     <= dvd_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      set_ff     <= set_in;
      start_ff   <= start_in;
      len_ff     <= len_in;
      rd_way_ff  <= rd_way_in;
      lim_ff     <= lim_in;
      cmp_way_ff <= cmp_way_in;
      pick_ff    <= pick_in;
      best_ff    <= best_in;
      status_ff  <= status_in;
      slot_ff    <= slot_in;
      bnum_ff    <= bnum_in;
      bstart_ff  <= bstart_in;
      blen_ff    <= blen_in;
   end

   // tag and stamp memories, one read and one write port
   always_ff @(posedge clock) begin
      if (issue_now) begin
         rd_tag_ff   <= tag_mem[rd_addr];
         rd_stamp_ff <= stamp_mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
      if (cmd.commit) begin
         stamp_mem[wr_addr] <= use_ctr_ff;
         if (!hit_ff) begin
            tag_mem[wr_addr] <= quo_ff;
         end
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_slot_index   = slot_ff;
   assign rsp_block_number = bnum_ff;
   assign rsp_block_start  = bstart_ff;
   assign rsp_block_length = blen_ff;

endmodule

`default_nettype wire

// ----- rtl/block_cache_lru_lookup.sv -----
// Block cache tag lookup with least-recently-used replacement.
// A request transaction carries a tuple index. The block computes its block
// number (index / block_size), picks the set (block number mod set count, one
// fully associative set for 16 slots or fewer, else sets of 4 ways), searches
// the set, and returns one response transaction: hit, miss with the claimed
// slot, or out of range, plus block number, start and clipped length.
// The user must write the registers through the csr port only while no
// transaction is in flight; the block itself does not enforce this. A lookup
// runs the 32-step serial divider, then a way search over 1 to 16 ways that
// reads one slot per cycle from the tag/stamp memory. Out-of-range requests
// answer without the divider and the search. One request is in flight at a
// time; the next is taken once the previous result sits in the output
// register, even if the receiver has not yet taken it. A stalled receiver
// holds the response and, once the next lookup finishes, holds that lookup
// too.
// Reset empties all slots (per-slot valid bits), sets the use counter to one
// and the registers to block size 65536, 1 tuple, 16 slots.
// Depends on blru_pkg, blru_csr, blru_ctrl, blru_dpath.
`default_nettype none

module block_cache_lru_lookup #(
   parameter int MAX_SLOTS = blru_pkg::MAX_SLOTS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [blru_pkg::TUPLE_W-1:0]       req_tuple_index,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [blru_pkg::STATUS_W-1:0]      rsp_status,
   output logic [blru_pkg::SLOT_IDX_W-1:0]    rsp_slot_index,
   output logic [blru_pkg::TUPLE_W-1:0]       rsp_block_number,
   output logic [blru_pkg::TUPLE_W-1:0]       rsp_block_start,
   output logic [blru_pkg::BSIZE_W-1:0]       rsp_block_length,
   input  logic                               csr_wr_en,
   input  logic [blru_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [blru_pkg::CSR_DATA_W-1:0]    csr_wr_data
);
   import blru_pkg::*;

   localparam int CNT_W = $clog2(MAX_SLOTS+1);

   logic [BSIZE_W-1:0] block_size_eff;
   logic [TUPLE_W-1:0] total_tuples;
   logic [CNT_W-1:0]   slot_count_eff;
   cmd_type            cmd;
   stat_type           stat;

   blru_csr #(
      .MAX_SLOTS(MAX_SLOTS)
   ) u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .block_size_eff (block_size_eff),
      .total_tuples   (total_tuples),
      .slot_count_eff (slot_count_eff)
   );

   blru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   blru_dpath #(
      .MAX_SLOTS(MAX_SLOTS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_tuple_index  (req_tuple_index),
      .block_size_eff   (block_size_eff),
      .total_tuples     (total_tuples),
      .slot_count_eff   (slot_count_eff),
      .rsp_status       (rsp_status),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_block_number (rsp_block_number),
      .rsp_block_start  (rsp_block_start),
      .rsp_block_length (rsp_block_length)
   );

`ifndef NO_ASSERTIONS
   // one lookup in flight: no second accept right after one
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a lookup is in flight");

   // out-of-range responses carry no block
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OOR |->
         rsp_block_number == '0 && rsp_block_length == '0 && rsp_slot_index == '0)
      else $error("out-of-range response with nonzero fields");

   // an in-range block always has at least one tuple
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OOR |-> rsp_block_length != '0)
      else $error("empty block length on an in-range response");

   // the memories are updated only after the way search has ended
   a_commit_after_search: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> $past(stat.search_done))
      else $error("slot commit without a finished search");
`endif

endmodule

`default_nettype wire
